### src/ifmt_pkg.sv
// Shared types, constants and the microcode table of the integer-to-ASCII formatter.
package ifmt_pkg;

  // Step counter of the sequencer.
  localparam int StepW = 3;
  typedef logic [StepW-1:0] step_t;

  // Digit register: ten four-bit digits, BCD for decimal or nibbles for hex.
  localparam int NumDigits = 10;
  localparam int DigitW    = 4 * NumDigits;
  localparam int CntW      = 4;
  localparam logic [CntW-1:0] DigitCount = CntW'(NumDigits);
  localparam logic [CntW-1:0] CntOne     = CntW'(1);

  // Double dabble runs one iteration per magnitude bit.
  localparam int MagW  = 32;
  localparam int IterW = 5;
  localparam logic [IterW-1:0] IterLast = IterW'(MagW - 1);

  // Saturating character count.
  localparam int CountW = 31;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Conversion selectors.
  localparam logic [1:0] OpSigned   = 2'd0;
  localparam logic [1:0] OpUnsigned = 2'd1;
  localparam logic [1:0] OpHexLower = 2'd2;
  localparam logic [1:0] OpHexUpper = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CfgPlus   = 2'd0;
  localparam logic [1:0] CfgSpace  = 2'd1;
  localparam logic [1:0] CfgPrefix = 2'd2;

  // ASCII codes.
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLowerX = 8'h78;
  localparam logic [7:0] CharUpperX = 8'h58;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;

  // Datapath action of one control word.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_DABBLE,
    ACT_SKIP,
    ACT_EMIT_PRE,
    ACT_EMIT_X,
    ACT_EMIT_DIGIT
  } action_t;

  // Jump condition of one control word.
  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_NO_PRE,
    JMP_IS_DEC,
    JMP_IS_HEX,
    JMP_ITER_MORE,
    JMP_LEAD_ZERO,
    JMP_NOT_LAST,
    JMP_ALWAYS
  } cond_t;

  typedef struct packed {
    action_t action;
    cond_t   cond;
    step_t   target;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic no_pre;
    logic is_dec;
    logic is_hex;
    logic iter_more;
    logic lead_zero;
    logic not_last;
    logic out_free;
  } dp_status_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    action_t action;
    logic    fire;
  } dp_ctrl_t;

  // Step addresses of the program.
  localparam step_t StepIdle   = 3'd0;
  localparam step_t StepPreChk = 3'd1;
  localparam step_t StepPre    = 3'd2;
  localparam step_t StepX      = 3'd3;
  localparam step_t StepBase   = 3'd4;
  localparam step_t StepDabble = 3'd5;
  localparam step_t StepSkip   = 3'd6;
  localparam step_t StepDigit  = 3'd7;

  // The program. Untaken jumps go to the next step.
  function automatic uword_t ucode_rom(step_t pc);
    uword_t w;
    case (pc)
      StepIdle:   w = '{ACT_LOAD,       JMP_NEVER,     StepIdle};
      StepPreChk: w = '{ACT_NONE,       JMP_NO_PRE,    StepBase};
      StepPre:    w = '{ACT_EMIT_PRE,   JMP_IS_DEC,    StepBase};
      StepX:      w = '{ACT_EMIT_X,     JMP_NEVER,     StepIdle};
      StepBase:   w = '{ACT_NONE,       JMP_IS_HEX,    StepSkip};
      StepDabble: w = '{ACT_DABBLE,     JMP_ITER_MORE, StepDabble};
      StepSkip:   w = '{ACT_SKIP,       JMP_LEAD_ZERO, StepSkip};
      StepDigit:  w = '{ACT_EMIT_DIGIT, JMP_NOT_LAST,  StepDigit};
      default:    w = '{ACT_NONE,       JMP_ALWAYS,    StepIdle};
    endcase
    return w;
  endfunction

endpackage

### src/ifmt_seq.sv
// Microcode sequencer: step counter, control word lookup and conditional jumps.
module ifmt_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ifmt_pkg::dp_status_t status,
  output ifmt_pkg::dp_ctrl_t  ctrl,
  output logic                in_stall
);

  ifmt_pkg::step_t  pc;
  ifmt_pkg::step_t  pc_next;
  ifmt_pkg::uword_t word;
  logic             fire;
  logic             take;

  assign word = ifmt_pkg::ucode_rom(pc);

  // A step executes when its transaction partner is ready.
  always_comb begin
    case (word.action)
      ifmt_pkg::ACT_LOAD:       fire = in_valid;
      ifmt_pkg::ACT_EMIT_PRE,
      ifmt_pkg::ACT_EMIT_X,
      ifmt_pkg::ACT_EMIT_DIGIT: fire = status.out_free;
      default:                  fire = 1'b1;
    endcase
  end

  // Jump condition select.
  always_comb begin
    case (word.cond)
      ifmt_pkg::JMP_NO_PRE:    take = status.no_pre;
      ifmt_pkg::JMP_IS_DEC:    take = status.is_dec;
      ifmt_pkg::JMP_IS_HEX:    take = status.is_hex;
      ifmt_pkg::JMP_ITER_MORE: take = status.iter_more;
      ifmt_pkg::JMP_LEAD_ZERO: take = status.lead_zero;
      ifmt_pkg::JMP_NOT_LAST:  take = status.not_last;
      ifmt_pkg::JMP_ALWAYS:    take = 1'b1;
      default:                 take = 1'b0;
    endcase
  end

  // The last step falls through to step zero when the step counter wraps.
  always_comb begin
    if (!fire) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + ifmt_pkg::step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ifmt_pkg::StepIdle;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.action = word.action;
  assign ctrl.fire   = fire;
  assign in_stall    = (word.action != ifmt_pkg::ACT_LOAD);

endmodule

### src/ifmt_dp.sv
// Datapath: magnitude and digit registers, double dabble, character select and output register.
module ifmt_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  ifmt_pkg::dp_ctrl_t   ctrl,
  input  logic [31:0]          value,
  input  logic [1:0]           opcode,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic                 cfg_bit,
  input  logic                 out_stall,
  output ifmt_pkg::dp_status_t status,
  output logic                 out_valid,
  output logic [7:0]           char_out,
  output logic                 last,
  output logic [30:0]          total_chars
);

  logic                         plus_flag;
  logic                         space_flag;
  logic                         hex_prefix;
  logic [1:0]                   op;
  logic                         has_pre;
  logic [7:0]                   pre_char;
  logic [ifmt_pkg::MagW-1:0]    mag;
  logic [ifmt_pkg::DigitW-1:0]  digits;
  logic [ifmt_pkg::DigitW-1:0]  adjusted;
  logic [ifmt_pkg::IterW-1:0]   iter;
  logic [ifmt_pkg::CntW-1:0]    cnt;
  logic [ifmt_pkg::CountW-1:0]  count;
  logic [ifmt_pkg::CountW-1:0]  count_next;
  logic [3:0]                   top_digit;
  logic [7:0]                   digit_char;
  logic [7:0]                   emit_char;
  logic                         emit;
  logic                         out_free;
  logic                         load_has_pre;
  logic [7:0]                   load_pre_char;

  // Configuration registers keep bit zero of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_flag  <= 1'b0;
      space_flag <= 1'b0;
      hex_prefix <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ifmt_pkg::CfgPlus:   plus_flag  <= cfg_bit;
        ifmt_pkg::CfgSpace:  space_flag <= cfg_bit;
        ifmt_pkg::CfgPrefix: hex_prefix <= cfg_bit;
        default: ;
      endcase
    end
  end

  // Leading character chosen when a value is loaded.
  always_comb begin
    load_has_pre  = 1'b0;
    load_pre_char = ifmt_pkg::CharZero;
    if (opcode == ifmt_pkg::OpSigned) begin
      if (value[31]) begin
        load_has_pre  = 1'b1;
        load_pre_char = ifmt_pkg::CharMinus;
      end else if (plus_flag) begin
        load_has_pre  = 1'b1;
        load_pre_char = ifmt_pkg::CharPlus;
      end else if (space_flag) begin
        load_has_pre  = 1'b1;
        load_pre_char = ifmt_pkg::CharSpace;
      end
    end else if (opcode[1]) begin
      load_has_pre = hex_prefix;
    end
  end

  // One double dabble correction: add three to every digit of five or more.
  always_comb begin
    for (int i = 0; i < ifmt_pkg::NumDigits; i++) begin
      if (digits[4*i +: 4] >= 4'd5) begin
        adjusted[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      end else begin
        adjusted[4*i +: 4] = digits[4*i +: 4];
      end
    end
  end

  // Character of the most significant remaining digit.
  assign top_digit = digits[ifmt_pkg::DigitW-1 -: 4];

  always_comb begin
    if (top_digit < 4'd10) begin
      digit_char = ifmt_pkg::CharZero + {4'd0, top_digit};
    end else if (op == ifmt_pkg::OpHexUpper) begin
      digit_char = ifmt_pkg::CharUpperA + {4'd0, top_digit - 4'd10};
    end else begin
      digit_char = ifmt_pkg::CharLowerA + {4'd0, top_digit - 4'd10};
    end
  end

  always_comb begin
    case (ctrl.action)
      ifmt_pkg::ACT_EMIT_PRE: emit_char = pre_char;
      ifmt_pkg::ACT_EMIT_X:
        emit_char = (op == ifmt_pkg::OpHexUpper) ? ifmt_pkg::CharUpperX : ifmt_pkg::CharLowerX;
      default:                emit_char = digit_char;
    endcase
  end

  assign emit = ctrl.fire && (ctrl.action == ifmt_pkg::ACT_EMIT_PRE ||
                              ctrl.action == ifmt_pkg::ACT_EMIT_X ||
                              ctrl.action == ifmt_pkg::ACT_EMIT_DIGIT);

  assign count_next = (count == ifmt_pkg::CountMax) ? count
                                                    : count + ifmt_pkg::CountW'(1);

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      case (ctrl.action)
        ifmt_pkg::ACT_LOAD: begin
          op       <= opcode;
          has_pre  <= load_has_pre;
          pre_char <= load_pre_char;
          mag      <= (opcode == ifmt_pkg::OpSigned && value[31]) ? (32'd0 - value) : value;
          digits   <= opcode[1] ? {{(ifmt_pkg::DigitW - 32){1'b0}}, value} : '0;
          iter     <= '0;
          cnt      <= ifmt_pkg::DigitCount;
        end
        ifmt_pkg::ACT_DABBLE: begin
          digits <= {adjusted[ifmt_pkg::DigitW-2:0], mag[ifmt_pkg::MagW-1]};
          mag    <= {mag[ifmt_pkg::MagW-2:0], 1'b0};
          iter   <= iter + ifmt_pkg::IterW'(1);
        end
        ifmt_pkg::ACT_SKIP: begin
          if (status.lead_zero) begin
            digits <= {digits[ifmt_pkg::DigitW-5:0], 4'd0};
            cnt    <= cnt - ifmt_pkg::CntOne;
          end
        end
        ifmt_pkg::ACT_EMIT_DIGIT: begin
          digits <= {digits[ifmt_pkg::DigitW-5:0], 4'd0};
          cnt    <= cnt - ifmt_pkg::CntOne;
        end
        default: ;
      endcase
    end
  end

  // Output register and running count.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
    end else if (emit) begin
      out_valid <= 1'b1;
      count     <= count_next;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_out    <= emit_char;
      last        <= (ctrl.action == ifmt_pkg::ACT_EMIT_DIGIT) && (cnt == ifmt_pkg::CntOne);
      total_chars <= count_next;
    end
  end

  assign out_free = !out_valid || !out_stall;

  assign status.no_pre    = !has_pre;
  assign status.is_dec    = !op[1];
  assign status.is_hex    = op[1];
  assign status.iter_more = (iter != ifmt_pkg::IterLast);
  assign status.lead_zero = (top_digit == 4'd0) && (cnt != ifmt_pkg::CntOne);
  assign status.not_last  = (cnt != ifmt_pkg::CntOne);
  assign status.out_free  = out_free;

endmodule

### src/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: sequencer, datapath and configuration port.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    value[31:0], opcode[1:0]
//   output   out        out_valid / out_stall  char_out[7:0], last, total_chars[30:0]
//   config   in         cfg_valid / cfg_ready  cfg_index[1:0], cfg_data[31:0]
//
// A decimal item runs the three setup steps (a fourth with a sign character), one double dabble
// step per magnitude bit, one step per skipped leading zero plus one, and one per digit.
// A hex item skips the double dabble loop; the 0x prefix adds a step for each of its characters.
// The microcode step counter sets the rate; one character leaves per cycle at most.
// Reset is synchronous and clears the step counter, output valid, count and flags.
// A stall on the output holds the program at its emitting step; the input is taken
// only at the idle step. Configuration writes are always ready.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  input  logic [1:0]  opcode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  char_out,
  output logic        last,
  output logic [30:0] total_chars,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  ifmt_pkg::dp_ctrl_t   ctrl;
  ifmt_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ifmt_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  ifmt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .value       (value),
    .opcode      (opcode),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_bit     (cfg_data[0]),
    .out_stall   (out_stall),
    .status      (status),
    .out_valid   (out_valid),
    .char_out    (char_out),
    .last        (last),
    .total_chars (total_chars)
  );

endmodule
